[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cht_pkg.sv]
package cht_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [8:0] BUCKET_COUNT_RESET = 9'd251;

    // Item passed from the front end to the back end
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [31:0] value;
    } t_op;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_INIT,
        BS_HEAD,
        BS_HEAD_WAIT,
        BS_NODE,
        BS_NODE_WAIT,
        BS_CHECK,
        BS_UNLINK,
        BS_INS,
        BS_RESULT
    } t_back_state;

endpackage

[hdl/chained_hash_table.sv]
// Chained hash table, 16-bit keys, 32-bit values.
// Input channel: i_valid / o_stall with i_kind, i_key, i_value
// (0 insert, 1 delete, 2 lookup). Output channel: o_valid / i_stall with
// o_status (0 done, 1 not found, 2 pool full) and o_value_res.
// One result per item, in order. The bucket is the key modulo
// i_bucket_count (0 acts as 1, above NUM_BUCKETS as NUM_BUCKETS); the user
// must write it via i_cfg_we / i_cfg_wdata while idle (not enforced).
// The front end runs a bit-serial 16-step divider and then hands the item
// to the queue; the back end reads the bucket head, then for an insert
// links a new node, or for a lookup checks chain nodes until a hit or the
// end of the chain, with an unlink step more for a delete that hits. The
// front end takes a new item only after queuing the last; front and back
// overlap, so throughput is set by the slower of the two.
// After reset the back end clears bucket heads and links the free list,
// one entry per cycle over the larger table rounded up to a power of two;
// items wait in the front end.
// When the receiver stalls, the result holds; the back end can finish one
// more item and wait with it, and the front end can hold one more.
module chained_hash_table #(
    parameter int NUM_BUCKETS = 256,
    parameter int POOL_SIZE   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_value_res,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata
);
    import cht_pkg::*;

    // index width covers the larger of the two tables
    localparam int BW = (NUM_BUCKETS > POOL_SIZE) ? $clog2(NUM_BUCKETS)
                                                  : $clog2(POOL_SIZE);
    localparam int PW = BW;

    logic [8:0]    r_bucket_count;
    logic [BW:0]   w_bc;
    t_op           w_op;
    logic          w_q_valid, w_q_stall;
    t_op           w_q_op;
    logic [BW-1:0] w_q_bucket;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    // clamp to NUM_BUCKETS before the front end sees it
    always_comb begin
        if (32'(r_bucket_count) > NUM_BUCKETS) w_bc = (BW+1)'(NUM_BUCKETS);
        else w_bc = (BW+1)'(r_bucket_count);
    end

    assign w_op = '{kind: i_kind, key: i_key, value: i_value};

    cht_front #(.BW(BW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_stall,
        .i_op(w_op), .i_bucket_count(w_bc),
        .o_q_valid(w_q_valid), .o_q_op(w_q_op), .o_q_bucket(w_q_bucket),
        .i_q_stall(w_q_stall)
    );

    cht_back #(.BW(BW), .PW(PW), .NODES(POOL_SIZE)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_stall(w_q_stall),
        .i_q_op(w_q_op), .i_q_bucket(w_q_bucket),
        .o_valid, .i_stall, .o_status, .o_value_res
    );
endmodule

[hdl/cht_front.sv]
// Front end: takes an item, reduces the key modulo the bucket count by
// restoring division one bit a cycle, then queues item and bucket.
module cht_front #(
    parameter int BW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cht_pkg::t_op      i_op,
    input  logic [BW:0]       i_bucket_count,
    output logic              o_q_valid,
    output cht_pkg::t_op      o_q_op,
    output logic [BW-1:0]     o_q_bucket,
    input  logic              i_q_stall
);
    import cht_pkg::*;

    localparam int CW = $clog2(17);

    t_front_state r_state, n_state;
    t_op          r_op;
    logic [16:0]  r_rem;
    logic [15:0]  r_quo;
    logic [CW-1:0] r_cnt;
    logic [BW:0]  r_div;
    logic [16:0]  w_trial;
    logic         w_ge;

    // divisor clamp: zero acts as one, above the table size acts as the size
    logic [BW:0] w_div;
    always_comb begin
        w_div = i_bucket_count;
        if (w_div == '0) w_div = {{BW{1'b0}}, 1'b1};
        else if (w_div > (BW+1)'(1 << BW)) w_div = (BW+1)'(1 << BW);
    end

    assign w_trial = {r_rem[15:0], r_quo[15]};
    assign w_ge    = w_trial >= 17'(r_div);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_valid) n_state = FS_DIV;
            FS_DIV:  if (r_cnt == CW'(15)) n_state = FS_PUSH;
            FS_PUSH: if (!i_q_stall) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = (r_state != FS_IDLE);
        o_q_valid = (r_state == FS_PUSH);
    end

    assign o_q_op     = r_op;
    assign o_q_bucket = r_rem[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == FS_IDLE && i_valid) begin
            r_op  <= i_op;
            r_quo <= i_op.key;
            r_rem <= '0;
            r_cnt <= '0;
            r_div <= w_div;
        end else if (r_state == FS_DIV) begin
            r_rem <= w_ge ? w_trial - 17'(r_div) : w_trial;
            r_quo <= {r_quo[14:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == FS_PUSH,
        r_rem < 17'(r_div), "bucket not below bucket count")
    `ASSERT_NEXT(a_push_holds, i_clk, i_rst_n, o_q_valid && i_q_stall,
        o_q_valid && $stable(o_q_bucket), "queued bucket changed while stalled")
    `ASSERT_NEXT(a_accept_divides, i_clk, i_rst_n, r_state == FS_IDLE && i_valid,
        r_state == FS_DIV, "accepted item did not start the divider")
endmodule

[hdl/cht_back.sv]
// Back end: reads the bucket head, walks its chain through the node
// memories for a delete or lookup, and applies insert, delete or lookup.
module cht_back #(
    parameter int BW = 8,
    parameter int PW = 8,
    parameter int NODES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_stall,
    input  cht_pkg::t_op      i_q_op,
    input  logic [BW-1:0]     i_q_bucket,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [31:0]       o_value_res
);
    import cht_pkg::*;

    localparam int NB = 1 << BW;
    localparam int NP = 1 << PW;
    // null pointer: one past the last node in use
    localparam logic [PW:0] NIL = (PW+1)'(NODES);

    logic [PW:0]  m_head [NB];
    logic [15:0]  m_key  [NP];
    logic [31:0]  m_val  [NP];
    logic [PW:0]  m_next [NP];

    t_back_state  r_state, n_state;
    t_op          r_op;
    logic [BW-1:0] r_bucket;
    logic [PW:0]  r_free;
    logic [PW:0]  r_cur, r_prev;
    logic [PW:0]  r_head_rd;
    logic [15:0]  r_key_rd;
    logic [31:0]  r_val_rd;
    logic [PW:0]  r_next_rd;
    logic [PW:0]  r_free_next_rd;
    logic [PW:0]  r_steps;
    logic [BW:0]  r_init;
    logic         r_ovalid;
    logic [1:0]   r_status;
    logic [31:0]  r_res;
    logic [1:0]   r_out_status;
    logic [31:0]  r_out_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_INIT:      if (r_init == (BW+1)'(NB - 1)) n_state = BS_IDLE;
            BS_IDLE:      if (i_q_valid) n_state = BS_HEAD;
            BS_HEAD:      n_state = BS_HEAD_WAIT;
            BS_HEAD_WAIT: n_state = (r_op.kind == KIND_INSERT) ? BS_INS : BS_NODE;
            BS_NODE:      n_state = BS_NODE_WAIT;
            BS_NODE_WAIT: n_state = BS_CHECK;
            BS_CHECK: begin
                if (r_op.kind != KIND_DELETE && r_op.kind != KIND_LOOKUP)
                    n_state = BS_RESULT;
                else if (r_cur >= NIL || r_steps == NIL) n_state = BS_RESULT;
                else if (r_key_rd == r_op.key)
                    n_state = (r_op.kind == KIND_DELETE) ? BS_UNLINK : BS_RESULT;
                else n_state = BS_NODE;
            end
            BS_UNLINK:    n_state = BS_RESULT;
            BS_INS:       n_state = BS_RESULT;
            BS_RESULT:    if (!r_ovalid || !i_stall) n_state = BS_IDLE;
            default:      n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_stall = (r_state != BS_IDLE);
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_out_status;
    assign o_value_res = r_out_res;

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_head_rd      <= m_head[r_bucket];
        r_key_rd       <= m_key[r_cur[PW-1:0]];
        r_val_rd       <= m_val[r_cur[PW-1:0]];
        r_next_rd      <= m_next[r_cur[PW-1:0]];
        r_free_next_rd <= m_next[r_free[PW-1:0]];
    end

    // memory writes (one per state at most, per array)
    always_ff @(posedge i_clk) begin
        if (r_state == BS_INIT) begin
            m_head[r_init[BW-1:0]] <= NIL;
        end else if (r_state == BS_INS && r_free < NIL) begin
            m_head[r_bucket] <= r_free;
        end else if (r_state == BS_UNLINK && r_prev >= NIL) begin
            m_head[r_bucket] <= r_next_rd;
        end
        if (r_state == BS_INIT) begin
            m_next[r_init[PW-1:0]] <= (r_init == (BW+1)'(NODES - 1)) ? NIL
                : (PW+1)'(r_init) + (PW+1)'(1);
        end else if (r_state == BS_INS && r_free < NIL) begin
            m_next[r_free[PW-1:0]] <= r_head_rd;
        end else if (r_state == BS_UNLINK && r_prev < NIL) begin
            m_next[r_prev[PW-1:0]] <= r_next_rd;
        end else if (r_state == BS_RESULT && r_op.kind == KIND_DELETE
                     && r_status == ST_DONE && (!r_ovalid || !i_stall)
                     && r_cur < NIL) begin
            m_next[r_cur[PW-1:0]] <= r_free;
        end
        if (r_state == BS_INS && r_free < NIL) begin
            m_key[r_free[PW-1:0]] <= r_op.key;
            m_val[r_free[PW-1:0]] <= r_op.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_INIT;
            r_init   <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_INIT) r_init <= r_init + (BW+1)'(1);
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                BS_IDLE: begin
                    r_op     <= i_q_op;
                    r_bucket <= i_q_bucket;
                    r_status <= ST_MISS;
                    r_res    <= '0;
                end
                BS_HEAD_WAIT: begin
                    r_cur   <= r_head_rd;
                    r_prev  <= NIL;
                    r_steps <= '0;
                end
                BS_CHECK: begin
                    if ((r_op.kind == KIND_DELETE || r_op.kind == KIND_LOOKUP)
                        && r_cur < NIL && r_steps != NIL && r_key_rd == r_op.key) begin
                        r_status <= ST_DONE;
                        r_res    <= r_val_rd;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_next_rd;
                        r_steps <= r_steps + (PW+1)'(1);
                    end
                end
                BS_INS: begin
                    if (r_free >= NIL) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_DONE;
                        r_free   <= r_free_next_rd;
                    end
                end
                BS_RESULT: begin
                    // output slot is free or drains at this edge
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid     <= 1'b1;
                        r_out_status <= r_status;
                        r_out_res    <= r_res;
                        if (r_op.kind == KIND_DELETE && r_status == ST_DONE)
                            r_free <= r_cur;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_free_ok, i_clk, i_rst_n, 1'b1,
        r_free <= NIL, "free head out of range")
    `ASSERT_IMPL(a_full_zero, i_clk, i_rst_n, o_valid && o_status == ST_FULL,
        o_value_res == '0, "full status with nonzero value")
    `ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && o_status == ST_MISS,
        o_value_res == '0, "miss with nonzero value")
endmodule
